// ===== sv/icj_pkg.sv =====
// ----------------------------------------------------------------------------
// icj_pkg: shared types and codes for the interval cover jump table unit
// Command codes and field widths of the stream beats.
// ----------------------------------------------------------------------------
package icj_pkg;

  localparam int unsigned PosW   = 10;
  localparam int unsigned CountW = 12;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

endpackage

// ===== sv/icj_ram.sv =====
// ----------------------------------------------------------------------------
// icj_ram: single-port-write, one-read synchronous memory
// Read data registered.
// ----------------------------------------------------------------------------
module icj_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 10
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== sv/interval_cover_jump_table_unit.sv =====
// Build: level 0 takes read and write states a coordinate, others read, mid and write.
// One item at a time; after reset the reach store is swept clear, and no beat
// is accepted until the sweep ends.
// Reset: rst_ni async active low clears control state.
// ----------------------------------------------------------------------------
// interval_cover_jump_table_unit: fewest segments covering a range
// Reach store and jump levels held in synchronous RAMs, walked by one FSM.
// ----------------------------------------------------------------------------
module interval_cover_jump_table_unit #(
  parameter int unsigned COORD_COUNT = 1024,
  parameter int unsigned LEVELS      = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] cmd, [11:2] left_pos, [21:12] right_pos, zero fill
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [11:0] segment_count, zero fill
  output logic [15:0] m_axis_tdata
);

  localparam int unsigned AW  = (COORD_COUNT > 1) ? $clog2(COORD_COUNT) : 1;
  localparam int unsigned LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned JAW = $clog2(LEVELS * COORD_COUNT);
  localparam int unsigned PW  = icj_pkg::PosW;
  localparam int unsigned CW  = icj_pkg::CountW;
  localparam logic [AW:0] LastC = (AW+1)'(COORD_COUNT - 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_ADD_RD, S_ADD_WR, S_B0_RD, S_B0_WR, S_BK_RD, S_BK_MID,
    S_BK_WR, S_Q_RD, S_Q_CHK, S_Q_FIN, S_Q_END, S_OUT
  } state_e;

  state_e          state_q;
  logic [AW:0]     c_q;
  logic [AW-1:0]   cur_q, end_q, run_q;
  logic [LW-1:0]   k_q;
  logic [CW-1:0]   cnt_q, res_q;

  // farthest store
  logic          f_we;
  logic [AW-1:0] f_wa, f_ra, f_wd, f_rd;
  // jump store
  logic           j_we;
  logic [JAW-1:0] j_wa, j_ra;
  logic [AW-1:0]  j_wd, j_rd;

  icj_ram #(.Depth(COORD_COUNT), .Width(AW)) u_far (
    .clk_i, .we_i(f_we), .waddr_i(f_wa), .wdata_i(f_wd), .raddr_i(f_ra),
    .rdata_o(f_rd));
  icj_ram #(.Depth(LEVELS * COORD_COUNT), .Width(AW)) u_jmp (
    .clk_i, .we_i(j_we), .waddr_i(j_wa), .wdata_i(j_wd), .raddr_i(j_ra),
    .rdata_o(j_rd));

  logic [1:0]    in_cmd;
  logic [PW-1:0] in_l, in_r;
  logic [AW-1:0] cl_l, cl_r;
  assign in_cmd = s_axis_tdata[1:0];
  assign in_l   = s_axis_tdata[11:2];
  assign in_r   = s_axis_tdata[21:12];

  function automatic logic [AW-1:0] clampc(input logic [PW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w >= 32'(COORD_COUNT)) return AW'(COORD_COUNT - 1);
    return AW'(w);
  endfunction
  assign cl_l = clampc(in_l);
  assign cl_r = clampc(in_r);

  function automatic logic [JAW-1:0] jaddr(input logic [LW-1:0] k,
                                           input logic [AW-1:0] c);
    return JAW'(32'(k) * 32'(COORD_COUNT) + 32'(c));
  endfunction

  logic acc;
  assign s_axis_tready = (state_q == S_IDLE);
  assign acc = s_axis_tvalid && s_axis_tready;
  logic l_ok;
  assign l_ok = (32'(in_l) < 32'(COORD_COUNT));

  always_comb begin
    f_we = 1'b0; f_wa = cur_q; f_wd = end_q; f_ra = cl_l;
    j_we = 1'b0; j_wa = jaddr(k_q, c_q[AW-1:0]); j_wd = '0;
    j_ra = jaddr(k_q, cur_q);
    case (state_q)
      S_CLR: begin
        f_we = 1'b1; f_wa = c_q[AW-1:0]; f_wd = '0;
      end
      S_ADD_RD: f_ra = cur_q;
      S_ADD_WR: f_we = (end_q > f_rd);
      S_B0_RD: f_ra = c_q[AW-1:0];
      S_B0_WR: begin
        j_we = 1'b1;
        j_wd = ((f_rd > run_q) ? f_rd : run_q) > c_q[AW-1:0] ?
               ((f_rd > run_q) ? f_rd : run_q) : c_q[AW-1:0];
        j_wa = jaddr('0, c_q[AW-1:0]);
      end
      S_BK_RD: j_ra = jaddr(k_q - 1'b1, c_q[AW-1:0]);
      S_BK_MID: j_ra = jaddr(k_q - 1'b1, j_rd);
      S_BK_WR: begin
        j_we = 1'b1; j_wd = j_rd;
      end
      S_Q_FIN: j_ra = jaddr('0, cur_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      c_q     <= '0;
      k_q     <= '0;
    end else begin
      case (state_q)
        S_CLR: begin
          c_q <= c_q + 1'b1;
          if (c_q == LastC) state_q <= S_IDLE;
        end
        S_IDLE: if (acc) begin
          cur_q <= cl_l; end_q <= cl_r; cnt_q <= '0;
          case (in_cmd)
            icj_pkg::CMD_ADD:   if (l_ok) state_q <= S_ADD_RD;
            icj_pkg::CMD_BUILD: begin
              c_q <= '0; run_q <= '0; state_q <= S_B0_RD;
            end
            icj_pkg::CMD_QUERY: begin
              k_q <= LW'(LEVELS - 1);
              if (cl_r <= cl_l) begin
                res_q <= '0; state_q <= S_OUT;
              end else state_q <= S_Q_RD;
            end
            default: ;
          endcase
        end
        S_ADD_RD: state_q <= S_ADD_WR;
        S_ADD_WR: state_q <= S_IDLE;
        S_B0_RD: state_q <= S_B0_WR;
        S_B0_WR: begin
          if (f_rd > run_q) run_q <= f_rd;
          c_q <= c_q + 1'b1;
          if (c_q == LastC) begin
            if (LEVELS == 1) state_q <= S_IDLE;
            else begin
              k_q <= LW'(1); c_q <= '0; state_q <= S_BK_RD;
            end
          end else state_q <= S_B0_RD;
        end
        S_BK_RD: state_q <= S_BK_MID;
        S_BK_MID: state_q <= S_BK_WR;
        S_BK_WR: begin
          c_q <= c_q + 1'b1;
          state_q <= S_BK_RD;
          if (c_q == LastC) begin
            c_q <= '0;
            if (32'(k_q) == LEVELS - 1) state_q <= S_IDLE;
            else k_q <= k_q + 1'b1;
          end
        end
        S_Q_RD: state_q <= S_Q_CHK;
        S_Q_CHK: begin
          if (j_rd < end_q) begin
            cur_q <= j_rd;
            cnt_q <= cnt_q + (CW'(1) << k_q);
          end
          if (k_q == '0) state_q <= S_Q_FIN;
          else begin
            k_q <= k_q - 1'b1; state_q <= S_Q_RD;
          end
        end
        S_Q_FIN: state_q <= S_Q_END;
        S_Q_END: begin
          res_q <= (j_rd >= end_q) ? cnt_q + 1'b1 : '1;
          state_q <= S_OUT;
        end
        S_OUT: if (m_axis_tready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {4'b0, res_q};

  a_no_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("ready while result held");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_clr_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_CLR |=> state_q != S_CLR) else $error("clear pass reentered");

endmodule
